// ===== src/php_pkg.sv =====
// Package for the priority header parser: types, character codes and parse-step functions.
`timescale 1ns / 1ps

package php_pkg;

   typedef enum logic [2:0] {
      PH_START,
      PH_TOKEN,
      PH_AFTER,
      PH_UVAL,
      PH_IVAL,
      PH_IQ,
      PH_SKIP,
      PH_TAIL
   } phase_type;

   typedef enum logic [1:0] {
      TK_EMPTY,
      TK_U,
      TK_I,
      TK_OTHER
   } token_type;

   typedef struct packed {
      phase_type  phase;
      token_type  kind;
      logic [2:0] urgency;
      logic       incremental;
      logic       still_valid;
   } parse_state_type;

   typedef struct packed {
      parse_state_type st;
      logic            more;
   } step_type;

   typedef struct packed {
      logic [7:0] header_byte;
      logic       last_byte;
   } req_data_type;

   typedef struct packed {
      logic [2:0] urgency;
      logic       incremental;
      logic       valid_res;
      logic [3:0] order_key;
   } rsp_data_type;

   // csr register indexes
   localparam logic CSR_DEFAULT_URGENCY     = 1'b0;
   localparam logic CSR_DEFAULT_INCREMENTAL = 1'b1;

   localparam logic [2:0] RESET_URGENCY     = 3'd3;
   localparam logic       RESET_INCREMENTAL = 1'b0;

   // number of chained steps evaluated for one byte (at least the worst case)
   localparam int STEP_DEPTH = 6;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_U     = 8'h75;

   function automatic logic is_ws(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // token has ended without a value: u is malformed, bare i sets incremental
   function automatic parse_state_type end_token(parse_state_type s);
      parse_state_type r;
      r = s;
      if (s.kind == TK_U) begin
         r.still_valid = 1'b0;
      end else if (s.kind == TK_I) begin
         r.incremental = 1'b1;
      end
      return r;
   endfunction

   function automatic parse_state_type close_header(parse_state_type s);
      parse_state_type r;
      r = s;
      case (s.phase)
         PH_TOKEN, PH_AFTER: begin
            r = end_token(s);
         end
         PH_UVAL, PH_IVAL, PH_IQ: begin
            r.still_valid = 1'b0;
         end
         default: begin
         end
      endcase
      r.phase = PH_TAIL;
      return r;
   endfunction

   // one dispatch of the byte; more set when the byte must be looked at again
   function automatic step_type parse_step(parse_state_type s, logic [7:0] c);
      step_type r;
      logic     ws;
      r.st   = s;
      r.more = 1'b0;
      ws     = is_ws(c);
      case (s.phase)
         PH_START: begin
            if (!ws) begin
               if (c == CH_EQ || c == CH_COMMA) begin
                  r.st.kind  = TK_OTHER;
                  r.st.phase = PH_AFTER;
                  r.more     = 1'b1;
               end else begin
                  r.st.kind  = (c == CH_U) ? TK_U : (c == CH_I) ? TK_I : TK_OTHER;
                  r.st.phase = PH_TOKEN;
               end
            end
         end
         PH_TOKEN: begin
            if (c == CH_EQ || c == CH_COMMA || ws) begin
               r.st.phase = PH_AFTER;
               r.more     = 1'b1;
            end else begin
               r.st.kind = TK_OTHER;
            end
         end
         PH_AFTER: begin
            if (!ws) begin
               if (c == CH_EQ) begin
                  r.st.phase = (s.kind == TK_U) ? PH_UVAL :
                               (s.kind == TK_I) ? PH_IVAL : PH_SKIP;
               end else begin
                  r.st       = end_token(s);
                  r.st.phase = PH_TAIL;
                  r.more     = 1'b1;
               end
            end
         end
         PH_UVAL: begin
            if (!ws) begin
               if (c >= CH_ZERO && c <= CH_SEVEN) begin
                  r.st.urgency = c[2:0];
               end else begin
                  r.st.still_valid = 1'b0;
                  r.more           = 1'b1;
               end
               r.st.phase = PH_TAIL;
            end
         end
         PH_IVAL: begin
            if (!ws) begin
               if (c == CH_QUEST) begin
                  r.st.phase = PH_IQ;
               end else begin
                  r.st.still_valid = 1'b0;
                  r.st.phase       = PH_TAIL;
                  r.more           = 1'b1;
               end
            end
         end
         PH_IQ: begin
            if (c == CH_ZERO || c == CH_ONE) begin
               r.st.incremental = c[0];
               r.st.phase       = PH_TAIL;
            end else begin
               r.st.still_valid = 1'b0;
               r.st.kind        = TK_OTHER;
               r.st.phase       = PH_TOKEN;
               r.more           = 1'b1;
            end
         end
         PH_SKIP: begin
            if (c == CH_COMMA) begin
               r.st.phase = PH_START;
            end
         end
         PH_TAIL: begin
            if (!ws) begin
               r.st.phase = PH_START;
               r.more     = (c != CH_COMMA);
            end
         end
         default: begin
            r.st.phase = PH_START;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== src/php_byte_step.sv =====
// Combinational next-state logic of the parser for one header byte.
`timescale 1ns / 1ps

module php_byte_step (
   input  php_pkg::parse_state_type state,
   input  logic                     past_term,
   input  logic [7:0]               header_byte,
   output php_pkg::parse_state_type next_state,
   output logic                     next_past_term,
   output php_pkg::parse_state_type final_state
);

   php_pkg::step_type chain [php_pkg::STEP_DEPTH+1];

   always_comb begin
      chain[0].st   = state;
      chain[0].more = 1'b1;
      for (int k = 0; k < php_pkg::STEP_DEPTH; k++) begin
         if (chain[k].more) begin
            chain[k+1] = php_pkg::parse_step(chain[k].st, header_byte);
         end else begin
            chain[k+1] = chain[k];
         end
      end
   end

   always_comb begin
      next_state     = state;
      next_past_term = past_term;
      if (!past_term) begin
         if (header_byte == php_pkg::CH_NUL) begin
            next_state     = php_pkg::close_header(state);
            next_past_term = 1'b1;
         end else begin
            next_state = chain[php_pkg::STEP_DEPTH].st;
         end
      end
      final_state = next_past_term ? next_state : php_pkg::close_header(next_state);
   end

endmodule

// ===== src/priority_header_parser.sv =====
// Top level of the priority header parser: state, config registers and result buffering.
`timescale 1ns / 1ps

// Parses one HTTP Priority header value, one byte per item, and gives one result item
// (urgency, incremental, valid flag, order key) on the item marked last_byte. One item is
// taken per cycle while req_stall is low: the whole byte, including lookahead re-dispatch,
// is resolved in one pass of next-state logic between the parse state and result registers.
// A result goes to the output register, or to the skid entry while rsp_stall holds it; the
// two-entry buffer keeps input flowing while a result waits, and req_stall rises only when
// both are full. Defaults written through the csr port also replace the held values at once.

module priority_header_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  php_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output php_pkg::rsp_data_type rsp_data,
   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [2:0]            csr_wdata
);

   php_pkg::parse_state_type state_ff, state_in;
   logic                     past_ff, past_in;
   logic [2:0]               def_urg_ff, def_urg_in;
   logic                     def_inc_ff, def_inc_in;

   php_pkg::rsp_data_type    out_ff, out_in;
   logic                     out_valid_ff, out_valid_in;
   php_pkg::rsp_data_type    skid_ff, skid_in;
   logic                     skid_valid_ff, skid_valid_in;

   php_pkg::parse_state_type step_state, final_state;
   logic                     step_past;
   logic                     accept, new_rsp, out_free, wr_urg, wr_inc;
   php_pkg::rsp_data_type    new_data;

   php_byte_step u_step (
      .state          (state_ff),
      .past_term      (past_ff),
      .header_byte    (req_data.header_byte),
      .next_state     (step_state),
      .next_past_term (step_past),
      .final_state    (final_state)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign new_rsp   = accept && req_data.last_byte;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign wr_urg    = csr_write_en && (csr_index == php_pkg::CSR_DEFAULT_URGENCY);
   assign wr_inc    = csr_write_en && (csr_index == php_pkg::CSR_DEFAULT_INCREMENTAL);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      new_data.urgency     = final_state.urgency;
      new_data.incremental = final_state.incremental;
      new_data.valid_res   = final_state.still_valid;
      new_data.order_key   = {final_state.urgency, final_state.incremental};
   end

   always_comb begin
      def_urg_in = wr_urg ? csr_wdata : def_urg_ff;
      def_inc_in = wr_inc ? csr_wdata[0] : def_inc_ff;

      state_in = state_ff;
      past_in  = past_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            state_in.phase       = php_pkg::PH_START;
            state_in.kind        = php_pkg::TK_EMPTY;
            state_in.urgency     = def_urg_ff;
            state_in.incremental = def_inc_ff;
            state_in.still_valid = 1'b1;
            past_in              = 1'b0;
         end else begin
            state_in = step_state;
            past_in  = step_past;
         end
      end
      if (wr_urg) begin
         state_in.urgency = def_urg_in;
      end
      if (wr_inc) begin
         state_in.incremental = def_inc_in;
      end
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = new_data;
            out_valid_in = new_rsp;
         end
      end else if (new_rsp) begin
         skid_in       = new_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         def_urg_ff            <= php_pkg::RESET_URGENCY;
         def_inc_ff            <= php_pkg::RESET_INCREMENTAL;
         state_ff.phase        <= php_pkg::PH_START;
         state_ff.kind         <= php_pkg::TK_EMPTY;
         state_ff.urgency      <= php_pkg::RESET_URGENCY;
         state_ff.incremental  <= php_pkg::RESET_INCREMENTAL;
         state_ff.still_valid  <= 1'b1;
         past_ff               <= 1'b0;
         out_valid_ff          <= 1'b0;
         skid_valid_ff         <= 1'b0;
      end else begin
         def_urg_ff    <= def_urg_in;
         def_inc_ff    <= def_inc_in;
         state_ff      <= state_in;
         past_ff       <= past_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

`ifndef NO_ASSERTIONS
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_last_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      new_rsp |=> rsp_valid)
      else $error("result missing after last byte");

   a_restart_after_last : assert property (@(posedge clock) disable iff (reset)
      (new_rsp && !csr_write_en) |=>
         (state_ff.phase == php_pkg::PH_START) && !past_ff && state_ff.still_valid)
      else $error("parser not restarted after last byte");

   a_order_key : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.order_key == {rsp_data.urgency, rsp_data.incremental}))
      else $error("order key does not match urgency and incremental");

   a_past_sticks : assert property (@(posedge clock) disable iff (reset)
      (past_ff && !(accept && req_data.last_byte)) |=> past_ff)
      else $error("terminator flag dropped inside a header");
`endif

endmodule
